>>> rtl/core/pwcf_pkg.sv
// Shared types, codes and the per-wall contact update for the peg/wall force block.
package pwcf_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_SIDE = 2'd1;
  localparam kind_t KIND_DOWN = 2'd2;
  localparam kind_t KIND_RSVD = 2'd3;  // never produced

  typedef enum logic [1:0] {
    REG_NONE   = 2'd0,
    REG_BESIDE = 2'd1,
    REG_ABOVE  = 2'd2,
    REG_INSIDE = 2'd3
  } region_t;

  // Config register indexes
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEFT_LIMIT  = 3'd0;
  localparam cfg_idx_t CFG_RIGHT_LIMIT = 3'd1;
  localparam cfg_idx_t CFG_UP_LIMIT    = 3'd2;
  localparam cfg_idx_t CFG_LEFT_STIFF  = 3'd3;
  localparam cfg_idx_t CFG_RIGHT_STIFF = 3'd4;
  localparam cfg_idx_t CFG_FORCE_CAP   = 3'd5;

  // One classified sample, handed from front to back.
  typedef struct packed {
    kind_t       l_kind;
    kind_t       r_kind;
    logic        fault;
    logic        l_neg;
    logic [31:0] l_mag;
    logic        r_neg;
    logic [31:0] r_mag;
  } job_t;

  typedef struct packed {
    kind_t kind;
    logic  fault;
  } contact_upd_t;

  function automatic contact_upd_t next_contact(region_t prev, region_t now, kind_t contact);
    contact_upd_t u;
    u.kind  = contact;
    u.fault = 1'b0;
    if (now != REG_INSIDE) begin
      u.kind = KIND_NONE;
    end else begin
      unique case (prev)
        REG_INSIDE: u.kind = contact;
        REG_BESIDE: u.kind = KIND_SIDE;
        REG_ABOVE:  u.kind = KIND_DOWN;
        REG_NONE:   u.fault = 1'b1;
        default:    u.fault = 1'b1;
      endcase
    end
    return u;
  endfunction

endpackage

>>> rtl/core/peg_wall_contact_force.sv
// Top level of the peg/virtual-wall contact force block: config registers and pipeline.
// An accepted word is classified into the queue, multiplied into stage 1, then summed,
//   clamped and held in the output register; it stalls there while out_tready is low.
// Throughput: one word per cycle unless out_tready stalls; the region state loop of the
//   front end is one compare stage; both 32x32 back-end multipliers are fully pipelined.
// Reset: synchronous, active low; clears wall regions, contacts, queue, pipeline valids and
//   returns the config registers to zero (force cap to 1.0 N).
module peg_wall_contact_force #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word: [31:0] pos_y, [63:32] pos_z
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // result word: [31:0] force_y, [63:32] force_z, [65:64] left_kind,
  //   [67:66] right_kind, [68] entry_fault, [71:69] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // config: 0 left_limit, 1 right_limit, 2 up_limit, 3 left_stiffness,
  //   4 right_stiffness, 5 force cap
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pwcf_pkg::*;

  logic signed [31:0] left_limit_r, right_limit_r, up_limit_r;
  logic [31:0]        left_stiff_r, right_stiff_r;
  logic [30:0]        force_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_limit_r  <= '0;
      right_limit_r <= '0;
      up_limit_r    <= '0;
      left_stiff_r  <= '0;
      right_stiff_r <= '0;
      force_cap_r   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_LIMIT:  left_limit_r  <= cfg_wdata;
        CFG_RIGHT_LIMIT: right_limit_r <= cfg_wdata;
        CFG_UP_LIMIT:    up_limit_r    <= cfg_wdata;
        CFG_LEFT_STIFF:  left_stiff_r  <= cfg_wdata;
        CFG_RIGHT_STIFF: right_stiff_r <= cfg_wdata;
        CFG_FORCE_CAP:   force_cap_r   <= cfg_wdata[30:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // front -> queue
  logic push, q_full, q_not_empty, pop;
  job_t push_job, head_job;

  pwcf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pos_y       (in_tdata[31:0]),
    .pos_z       (in_tdata[63:32]),
    .left_limit  (left_limit_r),
    .right_limit (right_limit_r),
    .up_limit    (up_limit_r),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job)
  );

  pwcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  // back end: multiply, sum, clamp, hold result for the consumer
  logic signed [31:0] force_y, force_z;
  logic [1:0]         left_kind, right_kind;
  logic               entry_fault;

  pwcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_not_empty),
    .job             (head_job),
    .job_pop         (pop),
    .left_stiffness  (left_stiff_r),
    .right_stiffness (right_stiff_r),
    .force_cap       (force_cap_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .force_y         (force_y),
    .force_z         (force_z),
    .left_kind       (left_kind),
    .right_kind      (right_kind),
    .entry_fault     (entry_fault)
  );

  assign out_tdata = {3'd0, entry_fault, right_kind, left_kind, force_z, force_y};

  // the reserved contact code is never produced
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (left_kind != KIND_RSVD && right_kind != KIND_RSVD))
    else $error("illegal contact kind on output");

endmodule

>>> rtl/core/pwcf_front.sv
// Front end: classifies each sample, updates wall regions/contacts, forms penetrations.
module pwcf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  left_limit,
  input  logic signed [31:0]  right_limit,
  input  logic signed [31:0]  up_limit,
  input  logic                q_full,
  output logic                push,
  output pwcf_pkg::job_t      job
);
  import pwcf_pkg::*;

  region_t l_region_r, l_region_nxt;
  region_t r_region_r, r_region_nxt;
  kind_t   l_contact_r, l_contact_nxt;
  kind_t   r_contact_r, r_contact_nxt;

  logic lt, gt, below;
  contact_upd_t l_upd, r_upd;
  logic signed [32:0] pen_l_side, pen_r_side, pen_up, pen_l, pen_r;
  logic [32:0] neg_l, neg_r;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign lt    = pos_y < left_limit;
  assign gt    = pos_y > right_limit;
  assign below = pos_z < up_limit;

  always_comb begin
    l_region_nxt = l_region_r;
    r_region_nxt = r_region_r;
    if (lt) begin
      if (below) begin
        l_region_nxt = REG_INSIDE;
      end else begin
        l_region_nxt = REG_ABOVE;
        r_region_nxt = REG_NONE;
      end
    end else if (gt) begin
      if (below) begin
        r_region_nxt = REG_INSIDE;
      end else begin
        r_region_nxt = REG_ABOVE;
        l_region_nxt = REG_NONE;
      end
    end else if (below) begin
      l_region_nxt = REG_BESIDE;
      r_region_nxt = REG_BESIDE;
    end else begin
      l_region_nxt = REG_NONE;
      r_region_nxt = REG_NONE;
    end
  end

  assign l_upd = next_contact(l_region_r, l_region_nxt, l_contact_r);
  assign r_upd = next_contact(r_region_r, r_region_nxt, r_contact_r);
  assign l_contact_nxt = l_upd.kind;
  assign r_contact_nxt = r_upd.kind;

  // penetrations, 33 bits so the difference never wraps
  assign pen_l_side = {left_limit[31], left_limit} - {pos_y[31], pos_y};
  assign pen_r_side = {right_limit[31], right_limit} - {pos_y[31], pos_y};
  assign pen_up     = {up_limit[31], up_limit} - {pos_z[31], pos_z};

  always_comb begin
    unique case (l_contact_nxt)
      KIND_SIDE: pen_l = pen_l_side;
      KIND_DOWN: pen_l = pen_up;
      default:   pen_l = '0;
    endcase
    unique case (r_contact_nxt)
      KIND_SIDE: pen_r = pen_r_side;
      KIND_DOWN: pen_r = pen_up;
      default:   pen_r = '0;
    endcase
  end

  // magnitude always fits 32 bits
  assign neg_l = -pen_l;
  assign neg_r = -pen_r;

  always_comb begin
    job.l_kind = l_contact_nxt;
    job.r_kind = r_contact_nxt;
    job.fault  = l_upd.fault | r_upd.fault;
    job.l_neg  = pen_l[32];
    job.l_mag  = pen_l[32] ? neg_l[31:0] : pen_l[31:0];
    job.r_neg  = pen_r[32];
    job.r_mag  = pen_r[32] ? neg_r[31:0] : pen_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_region_r  <= REG_NONE;
      r_region_r  <= REG_NONE;
      l_contact_r <= KIND_NONE;
      r_contact_r <= KIND_NONE;
    end else if (push) begin
      l_region_r  <= l_region_nxt;
      r_region_r  <= r_region_nxt;
      l_contact_r <= l_contact_nxt;
      r_contact_r <= r_contact_nxt;
    end
  end

  // a wall can only hold a contact while inside it
  a_contact_inside: assert property (@(posedge clk) disable iff (!rst_n)
    ((l_contact_r != KIND_NONE) |-> (l_region_r == REG_INSIDE)) and
    ((r_contact_r != KIND_NONE) |-> (r_region_r == REG_INSIDE)))
    else $error("contact held outside inside region");

endmodule

>>> rtl/core/pwcf_queue.sv
// Small FIFO of classified jobs between front and back.
module pwcf_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pwcf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pwcf_pkg::job_t head
);
  import pwcf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push |-> !full) and (pop |-> not_empty))
    else $error("queue overflow or underflow");

endmodule

>>> rtl/core/pwcf_back.sv
// Back end: spring multiplies, truncation, per-axis sum and clamp, output register.
module pwcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  pwcf_pkg::job_t      job,
  output logic                job_pop,
  input  logic [31:0]         left_stiffness,
  input  logic [31:0]         right_stiffness,
  input  logic [30:0]         force_cap,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  force_y,
  output logic signed [31:0]  force_z,
  output logic [1:0]          left_kind,
  output logic [1:0]          right_kind,
  output logic                entry_fault
);
  import pwcf_pkg::*;

  logic advance;

  // stage 1: products
  logic        s1_valid_r;
  logic [63:0] s1_prod_l_r, s1_prod_r_r;
  logic        s1_l_neg_r, s1_r_neg_r, s1_fault_r;
  kind_t       s1_l_kind_r, s1_r_kind_r;
  logic [63:0] prod_l, prod_r;

  // stage 2: output register
  logic               out_valid_r;
  logic signed [31:0] force_y_r, force_y_nxt;
  logic signed [31:0] force_z_r, force_z_nxt;
  kind_t              l_kind_r, r_kind_r;
  logic               fault_r;

  logic signed [49:0] t_l, t_r, ty_l, tz_l, ty_r, tz_r, sum_y, sum_z, maxf, minf;

  assign advance = !out_valid_r || out_ready;
  assign job_pop = advance && job_valid;

  assign prod_l = {32'd0, left_stiffness} * {32'd0, job.l_mag};
  assign prod_r = {32'd0, right_stiffness} * {32'd0, job.r_mag};

  // drop 16 fraction bits of the magnitude, then restore the sign
  assign t_l = s1_l_neg_r ? -$signed({2'b00, s1_prod_l_r[63:16]})
                          :  $signed({2'b00, s1_prod_l_r[63:16]});
  assign t_r = s1_r_neg_r ? -$signed({2'b00, s1_prod_r_r[63:16]})
                          :  $signed({2'b00, s1_prod_r_r[63:16]});

  assign ty_l = (s1_l_kind_r == KIND_SIDE) ? t_l : '0;
  assign tz_l = (s1_l_kind_r == KIND_DOWN) ? t_l : '0;
  assign ty_r = (s1_r_kind_r == KIND_SIDE) ? t_r : '0;
  assign tz_r = (s1_r_kind_r == KIND_DOWN) ? t_r : '0;

  assign sum_y = ty_l + ty_r;
  assign sum_z = tz_l + tz_r;
  assign maxf  = $signed({19'd0, force_cap});
  assign minf  = -maxf;

  always_comb begin
    priority if (sum_y > maxf) begin
      force_y_nxt = maxf[31:0];
    end else if (sum_y < minf) begin
      force_y_nxt = minf[31:0];
    end else begin
      force_y_nxt = sum_y[31:0];
    end
    priority if (sum_z > maxf) begin
      force_z_nxt = maxf[31:0];
    end else if (sum_z < minf) begin
      force_z_nxt = minf[31:0];
    end else begin
      force_z_nxt = sum_z[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod_l_r <= prod_l;
      s1_prod_r_r <= prod_r;
      s1_l_neg_r  <= job.l_neg;
      s1_r_neg_r  <= job.r_neg;
      s1_l_kind_r <= job.l_kind;
      s1_r_kind_r <= job.r_kind;
      s1_fault_r  <= job.fault;
      force_y_r   <= force_y_nxt;
      force_z_r   <= force_z_nxt;
      l_kind_r    <= s1_l_kind_r;
      r_kind_r    <= s1_r_kind_r;
      fault_r     <= s1_fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= job_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign force_y     = force_y_r;
  assign force_z     = force_z_r;
  assign left_kind   = l_kind_r;
  assign right_kind  = r_kind_r;
  assign entry_fault = fault_r;

  // a stalled output must not lose the product stage behind it
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_prod_l_r)))
    else $error("stage 1 overwritten during stall");

endmodule
